/* design/barker13_bpsk_pulse_generator_top_assert.svh */
// Assertion macros used by the Barker-13 pulse generator top level.
`ifndef BARKER13_BPSK_PULSE_GENERATOR_TOP_ASSERT_SVH
`define BARKER13_BPSK_PULSE_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define B13_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("barker13 pulse generator: assertion failed");
`define B13_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("barker13 pulse generator: reset assertion failed");
`else
`define B13_ASSERT(lbl, prop)
`define B13_ASSERT_RST(lbl, prop)
`endif

`endif

/* design/b13bpsk_pkg.sv */
// Package with the types, constants and sine table of the Barker-13 pulse generator.
`default_nettype none

package b13bpsk_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_SPAN_W      = SINE_ADDR_W + 1;

    localparam int BARKER_CHIPS = 13;
    // Bit i set where chip i of the Barker-13 code is negative.
    localparam logic [BARKER_CHIPS-1:0] CHIP_NEG_MASK = 13'h0A60;

    localparam logic [15:0] SINE_PEAK = 16'd32767;

    localparam logic [7:0]  DC_BIAS_RST          = 8'd128;
    localparam logic [15:0] PHASE_STEP_RST       = 16'd16384;
    localparam logic [4:0]  SAMPLES_PER_CHIP_RST = 5'd4;
    localparam logic [15:0] BUFFER_LENGTH_RST    = 16'd4096;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [1:0] {
        CFG_DC_BIAS          = 2'd0,
        CFG_PHASE_STEP       = 2'd1,
        CFG_SAMPLES_PER_CHIP = 2'd2,
        CFG_BUFFER_LENGTH    = 2'd3
    } cfg_idx_t;

    typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

    // One word after the state update, waiting for the sine and scaling stage.
    typedef struct packed {
        logic [15:0] phase;
        logic        chip_neg;
        logic        pulse;
        logic        last;
        logic [7:0]  bias;
    } stage_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       pulse;
        logic       last;
    } result_t;

    function automatic logic [15:0] quarter_sine(input int k);
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        theta = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = theta;
        term  = ((term * t2) >> 30) / 6;
        sum   = sum - term;
        term  = ((term * t2) >> 30) / 20;
        sum   = sum + term;
        term  = ((term * t2) >> 30) / 42;
        sum   = sum - term;
        term  = ((term * t2) >> 30) / 72;
        sum   = sum + term;
        term  = ((term * t2) >> 30) / 110;
        sum   = sum - term;
        term  = ((term * t2) >> 30) / 156;
        sum   = sum + term;
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        scaled = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        return scaled[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

/* design/b13bpsk_shaper.sv */
// Sine lookup, Barker sign and bias scaling with saturation for one word.
`default_nettype none

module b13bpsk_shaper
    import b13bpsk_pkg::*;
(
    input  wire stage_t  stage_in,
    output result_t      result_out
);

    logic [1:0]             quad;
    logic [31:0]            idx_scaled;
    logic [SINE_SPAN_W-1:0] idx;
    logic [SINE_SPAN_W-1:0] mirror;
    logic [15:0]            sine_mag;
    logic                   negative;
    logic [23:0]            prod;
    logic [8:0]             floor_part;
    logic [8:0]             ceil_part;
    logic [9:0]             sum_pos;
    logic [9:0]             diff_neg;
    logic [7:0]             shaped;

    always_comb begin
        quad       = stage_in.phase[15:14];
        idx_scaled = 32'(stage_in.phase[13:0]) * 32'(SINE_TABLE_DEPTH);
        idx        = idx_scaled[14 +: SINE_SPAN_W];
        mirror     = SINE_SPAN_W'(SINE_TABLE_DEPTH) - idx;
        if (quad[0]) begin
            if (mirror >= SINE_SPAN_W'(SINE_TABLE_DEPTH)) begin
                sine_mag = SINE_PEAK;
            end else begin
                sine_mag = SINE_ROM[mirror[SINE_ADDR_W-1:0]];
            end
        end else begin
            if (idx < SINE_SPAN_W'(SINE_TABLE_DEPTH)) begin
                sine_mag = SINE_ROM[idx[SINE_ADDR_W-1:0]];
            end else begin
                sine_mag = SINE_PEAK;
            end
        end
        negative   = stage_in.chip_neg ^ quad[1];
        prod       = 24'(stage_in.bias) * 24'(sine_mag);
        floor_part = prod[23:15];
        ceil_part  = 9'((25'(prod) + 25'd32767) >> 15);
        sum_pos    = 10'(stage_in.bias) + 10'(floor_part);
        diff_neg   = 10'(stage_in.bias) - 10'(ceil_part);
        if (negative) begin
            shaped = diff_neg[7:0];
        end else if (sum_pos > 10'd255) begin
            shaped = 8'd255;
        end else begin
            shaped = sum_pos[7:0];
        end
        result_out.sample = stage_in.pulse ? shaped : stage_in.bias;
        result_out.pulse  = stage_in.pulse;
        result_out.last   = stage_in.last;
    end

endmodule

`default_nettype wire

/* design/barker13_bpsk_pulse_generator_top.sv */
// An accepted word passes the stage register, then the output register.
// Throughput: one word per clock cycle while m_tready is high; the buffer counters
// update at acceptance, and the sine lookup and scaling sit in one stage before the
// output register. Reset (aresetn low, synchronous) empties both stages, restarts
// the buffer at sample zero and loads the registers with bias 128, step 16384, chip
// length 4 and buffer length 4096.
`default_nettype none
`include "barker13_bpsk_pulse_generator_top_assert.svh"

module barker13_bpsk_pulse_generator_top
    import b13bpsk_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wen,
    input  wire [1:0]  cfg_addr,
    input  wire [15:0] cfg_wdata,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // bit 0: start_req; bits 7..1: zero
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // bits 7..0: sample
    output logic       m_tuser,   // bit 0: in_pulse
    output logic       m_tlast
);

    logic [7:0]  dc_bias_reg;
    logic [15:0] phase_step_reg;
    logic [4:0]  samples_per_chip_reg;
    logic [15:0] buffer_length_reg;

    logic [15:0] sample_index_reg,      sample_index_next;
    logic [15:0] carrier_phase_reg,     carrier_phase_next;
    logic [3:0]  chip_sample_count_reg, chip_sample_count_next;
    logic [3:0]  chip_number_reg,       chip_number_next;

    stage_t      stage_reg, stage_next;
    logic        stage_valid_reg;
    result_t     result;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        m_user_reg;
    logic        m_last_reg;

    logic        in_fire;
    logic        advance;

    logic [15:0] cur_index;
    logic [15:0] cur_phase;
    logic [3:0]  cur_count;
    logic [3:0]  cur_chip;
    logic [4:0]  spc_eff;
    logic [15:0] blen_eff;
    logic        in_burst;
    logic        is_last;
    logic [4:0]  count_inc;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !stage_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_bias_reg          <= DC_BIAS_RST;
            phase_step_reg       <= PHASE_STEP_RST;
            samples_per_chip_reg <= SAMPLES_PER_CHIP_RST;
            buffer_length_reg    <= BUFFER_LENGTH_RST;
        end else if (cfg_wen) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DC_BIAS:          dc_bias_reg          <= cfg_wdata[7:0];
                CFG_PHASE_STEP:       phase_step_reg       <= cfg_wdata;
                CFG_SAMPLES_PER_CHIP: samples_per_chip_reg <= cfg_wdata[4:0];
                CFG_BUFFER_LENGTH:    buffer_length_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_index = s_tdata[0] ? 16'd0 : sample_index_reg;
        cur_phase = s_tdata[0] ? 16'd0 : carrier_phase_reg;
        cur_count = s_tdata[0] ? 4'd0  : chip_sample_count_reg;
        cur_chip  = s_tdata[0] ? 4'd0  : chip_number_reg;

        if (samples_per_chip_reg == 5'd0) begin
            spc_eff = 5'd1;
        end else if (samples_per_chip_reg > 5'd16) begin
            spc_eff = 5'd16;
        end else begin
            spc_eff = samples_per_chip_reg;
        end
        blen_eff = (buffer_length_reg == 16'd0) ? 16'd1 : buffer_length_reg;

        in_burst  = cur_chip < 4'(BARKER_CHIPS);
        is_last   = (17'(cur_index) + 17'd1) >= 17'(blen_eff);
        count_inc = 5'(cur_count) + 5'd1;

        sample_index_next      = cur_index + 16'd1;
        carrier_phase_next     = cur_phase + phase_step_reg;
        chip_sample_count_next = cur_count;
        chip_number_next       = cur_chip;
        if (in_burst) begin
            if (count_inc >= spc_eff) begin
                chip_sample_count_next = 4'd0;
                chip_number_next       = cur_chip + 4'd1;
            end else begin
                chip_sample_count_next = count_inc[3:0];
            end
        end
        if (is_last) begin
            sample_index_next      = 16'd0;
            carrier_phase_next     = 16'd0;
            chip_sample_count_next = 4'd0;
            chip_number_next       = 4'd0;
        end

        stage_next.phase    = cur_phase;
        stage_next.chip_neg = in_burst ? CHIP_NEG_MASK[cur_chip] : 1'b0;
        stage_next.pulse    = in_burst;
        stage_next.last     = is_last;
        stage_next.bias     = dc_bias_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg      <= 16'd0;
            carrier_phase_reg     <= 16'd0;
            chip_sample_count_reg <= 4'd0;
            chip_number_reg       <= 4'd0;
            stage_valid_reg       <= 1'b0;
            m_valid_reg           <= 1'b0;
        end else begin
            if (in_fire) begin
                sample_index_reg      <= sample_index_next;
                carrier_phase_reg     <= carrier_phase_next;
                chip_sample_count_reg <= chip_sample_count_next;
                chip_number_reg       <= chip_number_next;
                stage_valid_reg       <= 1'b1;
            end else if (advance) begin
                stage_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            stage_reg <= stage_next;
        end
        if (advance && stage_valid_reg) begin
            m_data_reg <= result.sample;
            m_user_reg <= result.pulse;
            m_last_reg <= result.last;
        end
    end

    b13bpsk_shaper u_shaper (
        .stage_in   (stage_reg),
        .result_out (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `B13_ASSERT_RST(a_reset_empties_output, !aresetn |=> !m_tvalid)
    `B13_ASSERT(a_chip_number_bounded, chip_number_reg <= 4'(BARKER_CHIPS))
    `B13_ASSERT(a_last_restarts_buffer,
        in_fire && is_last |=> sample_index_reg == 16'd0 && chip_number_reg == 4'd0)
    `B13_ASSERT(a_full_pipe_stalls_input, stage_valid_reg && !advance |-> !s_tready)

endmodule

`default_nettype wire
